FILE: src/four_wheel_incremental_pid_macros.svh
// ----------------------------------------------------------------------------
// Four-wheel incremental PID: assertion macros
// Shared forms of the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef FOUR_WHEEL_INCREMENTAL_PID_MACROS_SVH
`define FOUR_WHEEL_INCREMENTAL_PID_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FWPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fwpid: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FWPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fwpid: next-cycle check failed");

`endif

FILE: src/fwpid_pkg.sv
// ----------------------------------------------------------------------------
// Four-wheel incremental PID: package
// Field widths, register reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package fwpid_pkg;

	localparam int WHEELS_DEF     = 4;
	localparam int SPEED_BITS_DEF = 16;

	localparam int WHEEL_W    = 2;
	localparam int DRIVE_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [GAIN_W-1:0]  KP_RST    = 16'd1280;
	localparam logic [GAIN_W-1:0]  KI_RST    = 16'd563;
	localparam logic [GAIN_W-1:0]  KD_RST    = 16'd77;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd3400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_GAIN     = 2'd0,
		REG_KI_GAIN     = 2'd1,
		REG_KD_GAIN     = 2'd2,
		REG_DRIVE_LIMIT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  kp;
		logic [GAIN_W-1:0]  ki;
		logic [GAIN_W-1:0]  kd;
		logic [LIMIT_W-1:0] limit;
	} gains_t;

	// Travels with each word down the pipeline.
	typedef struct packed {
		logic [WHEEL_W-1:0] wheel;
		logic               ok;
	} tag_t;

endpackage

FILE: src/four_wheel_incremental_pid.sv
// ----------------------------------------------------------------------------
// Four-wheel incremental PID speed controller
// Velocity-form PID update of one wheel's drive value per input word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries a wheel index with that
//   wheel's measured and desired speed. The output channel (out_valid/
//   out_stall) returns the wheel index, the new saturated drive value and a
//   flag that is set when the value was held at the limit.
//   The gains and the limit are written through cfg_wen/cfg_index/cfg_data
//   while no word is in flight.
//   A word accepted into the input register passes through the products
//   register and the increment register to the result register, which
//   drives the output.
//   Throughput: one word per cycle; the stages are a plain pipeline and each
//   wheel's history and drive value are updated in the stage that reads them.
//   A stall on the output holds the result register; the stages behind it
//   keep filling, and in_stall rises only when every stage holds a word.
//   Reset clears all wheels' error history and drive values, empties the
//   pipeline and loads the default gains and limit.
// ----------------------------------------------------------------------------
`include "four_wheel_incremental_pid_macros.svh"

module four_wheel_incremental_pid #(
	parameter int WHEELS     = fwpid_pkg::WHEELS_DEF,
	parameter int SPEED_BITS = fwpid_pkg::SPEED_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [fwpid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fwpid_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [fwpid_pkg::WHEEL_W-1:0]        wheel,
	input  logic signed [SPEED_BITS-1:0]         measured_speed,
	input  logic signed [SPEED_BITS-1:0]         desired_speed,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [fwpid_pkg::WHEEL_W-1:0]        wheel_out,
	output logic signed [fwpid_pkg::DRIVE_W-1:0] drive,
	output logic                                 clamped
);
	import fwpid_pkg::*;

	gains_t gains;

	logic v_s1, v_s2, v_s3, v_q;
	logic free_1, free_2, free_3, free_q;

	logic [WHEEL_W-1:0]           wheel_s1;
	logic signed [SPEED_BITS-1:0] measured_s1, target_s1;

	tag_t                          tag_s2, tag_s3;
	logic signed [SPEED_BITS+18:0] p_kp_s2;
	logic signed [SPEED_BITS+17:0] p_ki_s2;
	logic signed [SPEED_BITS+20:0] p_kd_s2;
	logic signed [SPEED_BITS+14:0] inc_s3;

	// A stage can take a new word when it is empty or its word moves on.
	assign free_q = !v_q || !out_stall;
	assign free_3 = !v_s3 || free_q;
	assign free_2 = !v_s2 || free_3;
	assign free_1 = !v_s1 || free_2;

	assign in_stall  = !free_1;
	assign out_valid = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (free_1) v_s1 <= in_valid;
			if (free_2) v_s2 <= v_s1;
			if (free_3) v_s3 <= v_s2;
			if (free_q) v_q  <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (free_1) begin
			wheel_s1    <= wheel;
			measured_s1 <= measured_speed;
			target_s1   <= desired_speed;
		end
	end

	fwpid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.gains     (gains)
	);

	fwpid_err #(
		.WHEELS     (WHEELS),
		.SPEED_BITS (SPEED_BITS)
	) u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.gains       (gains),
		.ld          (free_2),
		.upd         (v_s1 && free_2),
		.wheel_s1    (wheel_s1),
		.measured_s1 (measured_s1),
		.target_s1   (target_s1),
		.tag_s2      (tag_s2),
		.p_kp_s2     (p_kp_s2),
		.p_ki_s2     (p_ki_s2),
		.p_kd_s2     (p_kd_s2)
	);

	fwpid_acc #(
		.SPEED_BITS (SPEED_BITS)
	) u_acc (
		.clk     (clk),
		.ld      (free_3),
		.tag_s2  (tag_s2),
		.p_kp_s2 (p_kp_s2),
		.p_ki_s2 (p_ki_s2),
		.p_kd_s2 (p_kd_s2),
		.tag_s3  (tag_s3),
		.inc_s3  (inc_s3)
	);

	fwpid_drv #(
		.WHEELS     (WHEELS),
		.SPEED_BITS (SPEED_BITS)
	) u_drv (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (free_q),
		.upd       (v_s3 && free_q),
		.tag_s3    (tag_s3),
		.inc_s3    (inc_s3),
		.limit     (gains.limit),
		.wheel_q   (wheel_out),
		.drive_q   (drive),
		.clamped_q (clamped)
	);

	// The input is held off only when every stage holds a word.
	`FWPID_ASSERT_IMP(a_stall_full, clk, arst_n, in_stall, v_s1 && v_s2 && v_s3 && v_q)
	// With nothing waiting at the output, the input is never held off.
	`FWPID_ASSERT_IMP(a_no_stall_empty, clk, arst_n, !out_valid, !in_stall)
	// A word behind a stalled result stays in its stage.
	`FWPID_ASSERT_NXT(a_s3_holds, clk, arst_n, v_q && out_stall && v_s3, v_s3)

endmodule

FILE: src/fwpid_cfg.sv
// ----------------------------------------------------------------------------
// Four-wheel incremental PID: configuration registers
// Holds the shared gain set and the drive limit, written by index.
// ----------------------------------------------------------------------------
module fwpid_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [fwpid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fwpid_pkg::CFG_DATA_W-1:0] cfg_data,
	output fwpid_pkg::gains_t                gains
);
	import fwpid_pkg::*;

	gains_t gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp    <= KP_RST;
			gains_q.ki    <= KI_RST;
			gains_q.kd    <= KD_RST;
			gains_q.limit <= LIMIT_RST;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_KP_GAIN:     gains_q.kp    <= cfg_data[GAIN_W-1:0];
				REG_KI_GAIN:     gains_q.ki    <= cfg_data[GAIN_W-1:0];
				REG_KD_GAIN:     gains_q.kd    <= cfg_data[GAIN_W-1:0];
				REG_DRIVE_LIMIT: gains_q.limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign gains = gains_q;

endmodule

FILE: src/fwpid_err.sv
// ----------------------------------------------------------------------------
// Four-wheel incremental PID: error stage
// Forms the speed error, keeps each wheel's error history and registers the
// three gain products.
// ----------------------------------------------------------------------------
module fwpid_err #(
	parameter int WHEELS     = fwpid_pkg::WHEELS_DEF,
	parameter int SPEED_BITS = fwpid_pkg::SPEED_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fwpid_pkg::gains_t                   gains,
	input  logic                                ld,
	input  logic                                upd,
	input  logic [fwpid_pkg::WHEEL_W-1:0]       wheel_s1,
	input  logic signed [SPEED_BITS-1:0]        measured_s1,
	input  logic signed [SPEED_BITS-1:0]        target_s1,
	output fwpid_pkg::tag_t                     tag_s2,
	output logic signed [SPEED_BITS+18:0]       p_kp_s2,
	output logic signed [SPEED_BITS+17:0]       p_ki_s2,
	output logic signed [SPEED_BITS+20:0]       p_kd_s2
);
	import fwpid_pkg::*;

	localparam int E_W    = SPEED_BITS + 1;
	localparam int D1_W   = SPEED_BITS + 2;
	localparam int D2_W   = SPEED_BITS + 4;
	localparam int G_W    = GAIN_W + 1;
	localparam int P_KP_W = G_W + D1_W;
	localparam int P_KI_W = G_W + E_W;
	localparam int P_KD_W = G_W + D2_W;
	localparam int IDX_W  = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam int WX_W   = IDX_W + WHEEL_W;

	logic signed [E_W-1:0] last_q  [WHEELS];
	logic signed [E_W-1:0] prior_q [WHEELS];

	logic [WX_W-1:0]        wx;
	logic [IDX_W-1:0]       idx;
	logic                   ok;
	logic signed [E_W-1:0]  e_c, e1_c, e2_c;
	logic signed [D1_W-1:0] d1_c;
	logic signed [D2_W-1:0] d2_c;
	logic signed [G_W-1:0]  kp_c, ki_c, kd_c;

	assign wx  = WX_W'(wheel_s1);
	assign ok  = wx < WX_W'(WHEELS);
	assign idx = wx[IDX_W-1:0];

	assign e_c  = E_W'(target_s1) - E_W'(measured_s1);
	assign e1_c = last_q[idx];
	assign e2_c = prior_q[idx];
	assign d1_c = D1_W'(e_c) - D1_W'(e1_c);
	assign d2_c = D2_W'(e_c) - (D2_W'(e1_c) <<< 1) + D2_W'(e2_c);

	assign kp_c = $signed({1'b0, gains.kp});
	assign ki_c = $signed({1'b0, gains.ki});
	assign kd_c = $signed({1'b0, gains.kd});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEELS; i++) begin
				last_q[i]  <= '0;
				prior_q[i] <= '0;
			end
		end else if (upd && ok) begin
			prior_q[idx] <= e1_c;
			last_q[idx]  <= e_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			tag_s2.wheel <= wheel_s1;
			tag_s2.ok    <= ok;
			p_kp_s2      <= P_KP_W'(kp_c * d1_c);
			p_ki_s2      <= P_KI_W'(ki_c * e_c);
			p_kd_s2      <= P_KD_W'(kd_c * d2_c);
		end
	end

endmodule

FILE: src/fwpid_acc.sv
// ----------------------------------------------------------------------------
// Four-wheel incremental PID: increment stage
// Sums the gain products and scales the Q8.8 sum down by 256, rounding
// toward zero.
// ----------------------------------------------------------------------------
module fwpid_acc #(
	parameter int SPEED_BITS = fwpid_pkg::SPEED_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          ld,
	input  fwpid_pkg::tag_t               tag_s2,
	input  logic signed [SPEED_BITS+18:0] p_kp_s2,
	input  logic signed [SPEED_BITS+17:0] p_ki_s2,
	input  logic signed [SPEED_BITS+20:0] p_kd_s2,
	output fwpid_pkg::tag_t               tag_s3,
	output logic signed [SPEED_BITS+14:0] inc_s3
);
	import fwpid_pkg::*;

	localparam int ACC_W = SPEED_BITS + 23;
	localparam int INC_W = ACC_W - 8;

	logic signed [ACC_W-1:0] acc_c, acc_r_c;

	assign acc_c = ACC_W'(p_kp_s2) + ACC_W'(p_ki_s2) + ACC_W'(p_kd_s2);
	// A negative sum gets 255 added first, so the shift rounds toward zero.
	assign acc_r_c = acc_c + $signed({{(ACC_W-8){1'b0}}, {8{acc_c[ACC_W-1]}}});

	always_ff @(posedge clk) begin
		if (ld) begin
			tag_s3 <= tag_s2;
			inc_s3 <= $signed(acc_r_c[ACC_W-1:ACC_W-INC_W]);
		end
	end

endmodule

FILE: src/fwpid_drv.sv
// ----------------------------------------------------------------------------
// Four-wheel incremental PID: drive stage
// Adds the increment to the wheel's drive value, saturates it at the limit,
// and holds the result word for the output channel.
// ----------------------------------------------------------------------------
`include "four_wheel_incremental_pid_macros.svh"

module fwpid_drv #(
	parameter int WHEELS     = fwpid_pkg::WHEELS_DEF,
	parameter int SPEED_BITS = fwpid_pkg::SPEED_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 ld,
	input  logic                                 upd,
	input  fwpid_pkg::tag_t                      tag_s3,
	input  logic signed [SPEED_BITS+14:0]        inc_s3,
	input  logic [fwpid_pkg::LIMIT_W-1:0]        limit,
	output logic [fwpid_pkg::WHEEL_W-1:0]        wheel_q,
	output logic signed [fwpid_pkg::DRIVE_W-1:0] drive_q,
	output logic                                 clamped_q
);
	import fwpid_pkg::*;

	localparam int SUM_W = SPEED_BITS + 16;
	localparam int IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam int WX_W  = IDX_W + WHEEL_W;

	logic signed [DRIVE_W-1:0] drv_q [WHEELS];

	logic [WX_W-1:0]         wx;
	logic [IDX_W-1:0]        idx;
	logic signed [SUM_W-1:0] sum_c, lim_p, lim_n, sel_c;
	logic                    clip_c;
	logic signed [DRIVE_W-1:0] res_c;

	assign wx  = WX_W'(tag_s3.wheel);
	assign idx = wx[IDX_W-1:0];

	assign sum_c = SUM_W'(drv_q[idx]) + SUM_W'(inc_s3);
	assign lim_p = SUM_W'($signed({1'b0, limit}));
	assign lim_n = -lim_p;

	always_comb begin
		sel_c  = sum_c;
		clip_c = 1'b0;
		if (!tag_s3.ok) begin
			sel_c = '0;
		end else if (sum_c > lim_p) begin
			sel_c  = lim_p;
			clip_c = 1'b1;
		end else if (sum_c < lim_n) begin
			sel_c  = lim_n;
			clip_c = 1'b1;
		end
	end

	assign res_c = sel_c[DRIVE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEELS; i++) begin
				drv_q[i] <= '0;
			end
		end else if (upd && tag_s3.ok) begin
			drv_q[idx] <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_q   <= '0;
			drive_q   <= '0;
			clamped_q <= 1'b0;
		end else if (ld) begin
			wheel_q   <= tag_s3.wheel;
			drive_q   <= res_c;
			clamped_q <= clip_c;
		end
	end

	// A saturated value must sit exactly on one of the two bounds.
	`FWPID_ASSERT_IMP(a_clip_on_bound, clk, arst_n, ld && clip_c, sel_c == lim_p || sel_c == lim_n)
	// Every drive value for a valid wheel lies within the bounds.
	`FWPID_ASSERT_IMP(a_within_bound, clk, arst_n, ld && tag_s3.ok, sel_c <= lim_p && sel_c >= lim_n)
	// A wheel index past the last wheel yields a zero, unclamped word.
	`FWPID_ASSERT_NXT(a_bad_wheel_zero, clk, arst_n, ld && !tag_s3.ok, drive_q == '0 && !clamped_q)

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Four-wheel incremental PID: testbench
// Writes the gains and the limit while the block is idle. Feeds wheel speed
// words from a directed table and then from random bursts, with random gaps
// and output stalls. Each output word is checked against a cycle-free model
// of the velocity-form PID update.
// ----------------------------------------------------------------------------
module testbench;

	import fwpid_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 80;
	localparam int HOLD_AFTER      = 600;
	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 250;

	typedef struct {
		logic [WHEEL_W-1:0]        wheel;
		logic signed [DRIVE_W-1:0] drive;
		logic                      clamped;
	} drive_word_t;

	typedef struct {
		bit                        is_cfg;
		cfg_reg_t                  idx;
		logic [CFG_DATA_W-1:0]     value;
		logic [WHEEL_W-1:0]        wheel;
		logic signed [15:0]        meas;
		logic signed [15:0]        targ;
		bit                        known;
		logic signed [DRIVE_W-1:0] exp_drive;
		logic                      exp_clamped;
	} plan_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wen;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	logic [WHEEL_W-1:0]          wheel;
	logic signed [15:0]          measured_speed;
	logic signed [15:0]          desired_speed;
	logic                        out_valid;
	logic                        out_stall;
	logic [WHEEL_W-1:0]          wheel_out;
	logic signed [DRIVE_W-1:0]   drive;
	logic                        clamped;

	// Model copy of the registers and of each wheel's history.
	longint kp_q, ki_q, kd_q, limit_q;
	longint err_last[WHEELS_DEF];
	longint err_prior[WHEELS_DEF];
	longint drive_now[WHEELS_DEF];

	drive_word_t expected_drive[$];
	plan_row_t   plan[$];
	int          error_count;
	int unsigned words_sent;
	int unsigned cycle_count;

	four_wheel_incremental_pid DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.wheel          (wheel),
		.measured_speed (measured_speed),
		.desired_speed  (desired_speed),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.wheel_out      (wheel_out),
		.drive          (drive),
		.clamped        (clamped)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic drive_word_t pid_predict(logic [WHEEL_W-1:0] w,
			logic signed [15:0] meas, logic signed [15:0] targ);
		longint err, err1, err2, acc, step, total;
		drive_word_t res;
		err  = longint'(targ) - longint'(meas);
		err1 = err_last[w];
		err2 = err_prior[w];
		acc  = kp_q * (err - err1) + ki_q * err + kd_q * (err - 2 * err1 + err2);
		// Signed division truncates toward zero, as the Q8.8 scaling needs.
		step = acc / 256;
		err_prior[w] = err1;
		err_last[w]  = err;
		total = drive_now[w] + step;
		res.wheel   = w;
		res.clamped = 1'b0;
		if (total > limit_q) begin
			total = limit_q;
			res.clamped = 1'b1;
		end else if (total < -limit_q) begin
			total = -limit_q;
			res.clamped = 1'b1;
		end
		drive_now[w] = total;
		res.drive = total[DRIVE_W-1:0];
		return res;
	endfunction

	function automatic plan_row_t item_row(logic [WHEEL_W-1:0] w, logic signed [15:0] meas,
			logic signed [15:0] targ, bit known = 1'b0,
			logic signed [DRIVE_W-1:0] d = '0, logic c = 1'b0);
		plan_row_t r;
		r.is_cfg      = 1'b0;
		r.idx         = REG_KP_GAIN;
		r.value       = '0;
		r.wheel       = w;
		r.meas        = meas;
		r.targ        = targ;
		r.known       = known;
		r.exp_drive   = d;
		r.exp_clamped = c;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		plan_row_t r;
		r = item_row('0, '0, '0);
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.value  = value;
		return r;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'hFFFF;
		if (r == 1)
			return 16'h0000;
		return CFG_DATA_W'($urandom_range(0, 2047));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_limit();
		int unsigned r;
		logic [LIMIT_W-1:0] lim;
		r = $urandom_range(0, 19);
		if (r < 2)
			lim = 15'h7FFF;
		else if (r == 2)
			lim = '0;
		else
			lim = LIMIT_W'($urandom_range(1, 8000));
		// The top data bit lies above the register and must be ignored.
		return {1'($urandom_range(0, 1)), lim};
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		$display("ERROR: %s", msg);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_KP_GAIN:     kp_q    = longint'(value[GAIN_W-1:0]);
			REG_KI_GAIN:     ki_q    = longint'(value[GAIN_W-1:0]);
			REG_KD_GAIN:     kd_q    = longint'(value[GAIN_W-1:0]);
			REG_DRIVE_LIMIT: limit_q = longint'(value[LIMIT_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Stops offering words and waits for every outstanding drive word.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic offer_word(input logic [WHEEL_W-1:0] w, input logic signed [15:0] meas,
			input logic signed [15:0] targ, input bit known = 1'b0,
			input logic signed [DRIVE_W-1:0] d = '0, input logic c = 1'b0);
		drive_word_t res;
		if (cfg_wen)
			cfg_wen <= 1'b0;
		in_valid       <= 1'b1;
		wheel          <= w;
		measured_speed <= meas;
		desired_speed  <= targ;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		res = pid_predict(w, meas, targ);
		if (known) begin
			res.drive   = d;
			res.clamped = c;
		end
		expected_drive.push_back(res);
		words_sent++;
	endtask

	task automatic random_gap();
		int unsigned r;
		r = $urandom_range(0, 49);
		if (r == 0) begin
			quiesce();
		end else if (r >= 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : result_check
		drive_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_drive.size() == 0) begin
				flag_error($sformatf("unexpected word: wheel %0d drive %0d clamped %0b",
					wheel_out, drive, clamped));
			end else begin
				want = expected_drive.pop_front();
				if (wheel_out !== want.wheel)
					flag_error($sformatf("wheel_out %0d, expected %0d", wheel_out, want.wheel));
				if (drive !== want.drive)
					flag_error($sformatf("wheel %0d drive %0d, expected %0d",
						want.wheel, drive, want.drive));
				if (clamped !== want.clamped)
					flag_error($sformatf("wheel %0d clamped %0b, expected %0b",
						want.wheel, clamped, want.clamped));
			end
		end
	end

	// Output side: stretches of varying stall density, plus one long hold
	// that lets the pipeline fill and push back on the input.
	initial begin : receiver
		bit          hold_done;
		int unsigned len, pct;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!hold_done && words_sent >= HOLD_AFTER) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				len = $urandom_range(1, 40);
				case ($urandom_range(0, 4))
					0, 1:    pct = 0;
					2:       pct = 30;
					3:       pct = 60;
					default: pct = 90;
				endcase
				repeat (len) begin
					out_stall <= ($urandom_range(0, 99) < pct);
					@(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		plan_row_t          row;
		int                 setpoint[WHEELS_DEF];
		int unsigned        sent, burst;
		logic [WHEEL_W-1:0] w;
		logic signed [15:0] meas, targ;

		arst_n         = 1'b0;
		cfg_wen        = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		wheel          = '0;
		measured_speed = '0;
		desired_speed  = '0;
		error_count    = 0;
		words_sent     = 0;
		kp_q           = longint'(KP_RST);
		ki_q           = longint'(KI_RST);
		kd_q           = longint'(KD_RST);
		limit_q        = longint'(LIMIT_RST);
		for (int i = 0; i < WHEELS_DEF; i++) begin
			err_last[i]  = 0;
			err_prior[i] = 0;
			drive_now[i] = 0;
			setpoint[i]  = 0;
		end

		// Default gains: idle wheel, then full-scale errors of both signs.
		plan.push_back(item_row(2'd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 1'b0));
		plan.push_back(item_row(2'd0, -16'sd32768, 16'sd32767, 1'b1, 16'sd3400, 1'b1));
		plan.push_back(item_row(2'd1, 16'sd32767, -16'sd32768, 1'b1, -16'sd3400, 1'b1));
		plan.push_back(item_row(2'd2, 16'sd100, 16'sd50));
		plan.push_back(item_row(2'd3, -16'sd7, 16'sd1234));
		plan.push_back(item_row(2'd0, 16'sd32767, 16'sd32767));
		plan.push_back(item_row(2'd1, -16'sd32768, -16'sd32768));
		// Integral gain of exactly one, so the increment equals the error.
		plan.push_back(cfg_row(REG_KP_GAIN, 16'd0));
		plan.push_back(cfg_row(REG_KI_GAIN, 16'd256));
		plan.push_back(cfg_row(REG_KD_GAIN, 16'd0));
		plan.push_back(cfg_row(REG_DRIVE_LIMIT, 16'd100));
		plan.push_back(item_row(2'd2, 16'sd0, 16'sd32767, 1'b1, 16'sd100, 1'b1));
		// Landing exactly on either bound does not count as clamping.
		plan.push_back(item_row(2'd2, 16'sd0, 16'sd0, 1'b1, 16'sd100, 1'b0));
		plan.push_back(item_row(2'd2, 16'sd200, 16'sd0, 1'b1, -16'sd100, 1'b0));
		plan.push_back(item_row(2'd2, 16'sd1, 16'sd0, 1'b1, -16'sd100, 1'b1));
		// Zero limit pins the drive at zero; any nonzero sum is clamped.
		plan.push_back(cfg_row(REG_DRIVE_LIMIT, 16'd0));
		plan.push_back(item_row(2'd3, 16'sd0, 16'sd5, 1'b1, 16'sd0, 1'b1));
		plan.push_back(item_row(2'd3, 16'sd0, 16'sd0, 1'b1, 16'sd0, 1'b0));
		// Smallest integral gain: partial increments truncate toward zero.
		plan.push_back(cfg_row(REG_KI_GAIN, 16'd1));
		plan.push_back(cfg_row(REG_DRIVE_LIMIT, 16'h7FFF));
		plan.push_back(item_row(2'd3, 16'sd255, 16'sd0, 1'b1, 16'sd0, 1'b0));
		plan.push_back(item_row(2'd3, 16'sd0, 16'sd255, 1'b1, 16'sd0, 1'b0));
		plan.push_back(item_row(2'd3, 16'sd256, 16'sd0, 1'b1, -16'sd1, 1'b0));
		// All gains at full scale; the top limit data bit is ignored.
		plan.push_back(cfg_row(REG_KP_GAIN, 16'hFFFF));
		plan.push_back(cfg_row(REG_KI_GAIN, 16'hFFFF));
		plan.push_back(cfg_row(REG_KD_GAIN, 16'hFFFF));
		plan.push_back(cfg_row(REG_DRIVE_LIMIT, 16'hFFFF));
		plan.push_back(item_row(2'd0, -16'sd32768, 16'sd32767));
		plan.push_back(item_row(2'd0, 16'sd32767, -16'sd32768));
		plan.push_back(item_row(2'd1, 16'sd0, -16'sd1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cfg) begin
				if (!cfg_wen)
					quiesce();
				write_reg(row.idx, row.value);
			end else begin
				offer_word(row.wheel, row.meas, row.targ, row.known,
					row.exp_drive, row.exp_clamped);
				random_gap();
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			quiesce();
			write_reg(REG_KP_GAIN, pick_gain());
			write_reg(REG_KI_GAIN, pick_gain());
			write_reg(REG_KD_GAIN, pick_gain());
			write_reg(REG_DRIVE_LIMIT, pick_limit());
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				burst = $urandom_range(1, 30);
				repeat (burst) begin
					w = WHEEL_W'($urandom_range(0, WHEELS_DEF - 1));
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5, 6: begin
							// Closed-loop style: a slowly moving setpoint with sensor noise.
							if ($urandom_range(0, 19) == 0)
								setpoint[w] = int'($urandom_range(0, 6000)) - 3000;
							targ = 16'(setpoint[w]);
							meas = 16'(setpoint[w] + int'($urandom_range(0, 600)) - 300);
						end
						7, 8: begin
							meas = 16'($urandom);
							targ = 16'($urandom);
						end
						default: begin
							case ($urandom_range(0, 3))
								0:       meas = -16'sd32768;
								1:       meas = 16'sd32767;
								2:       meas = 16'sd0;
								default: meas = -16'sd1;
							endcase
							case ($urandom_range(0, 3))
								0:       targ = -16'sd32768;
								1:       targ = 16'sd32767;
								2:       targ = 16'sd0;
								default: targ = -16'sd1;
							endcase
						end
					endcase
					offer_word(w, meas, targ);
					sent++;
				end
				random_gap();
			end
		end

		quiesce();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
